// ----- hdl/kst_pkg.sv -----
// Shared types and constants of the k-strongest radar return filter.
// Used by the store cells, the output drain and the top level; depends on nothing.
package kst_pkg;

   // Configuration register indexes and their values after reset.
   localparam logic CSR_K_COUNT   = 1'b0;
   localparam logic CSR_START_BIN = 1'b1;

   localparam logic [4:0]  K_COUNT_RESET   = 5'd5;
   localparam logic [11:0] START_BIN_RESET = 12'd50;

   // One input item: the power byte of a range bin and its row markers.
   typedef struct packed {
      logic [7:0] power;
      logic       last_bin;
      logic       scan_start;
   } kst_req_type;

   // One result item: a kept return of a finished azimuth row.
   typedef struct packed {
      logic [8:0]  azimuth_row;
      logic [11:0] bin_index;
      logic [7:0]  bin_power;
      logic        last_target;
   } kst_rsp_type;

   // A kept bin as held by one cell of the store.
   typedef struct packed {
      logic [7:0]  power;
      logic [11:0] index;
   } kst_entry_type;

   // Operation applied to the whole row of cells in the same cycle.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REPLACE,
      OP_REMOVE
   } kst_op_type;

   // Broadcast control from the top level to every cell.
   typedef struct packed {
      kst_op_type    op;
      logic          flush;
      logic          clear;
      kst_entry_type new_entry;
      logic [7:0]    min_power;
   } kst_ctrl_type;

   // What a cell shows its neighbours.
   typedef struct packed {
      logic          valid;
      logic          le;
      logic          mr;
      kst_entry_type entry;
   } kst_link_type;

endpackage

// ----- hdl/kst_cell.sv -----
// One cell of the sorted store: holds one kept bin and shifts it to or from its neighbours.
// Depends on kst_pkg for the entry, link and control types.
module kst_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  kst_pkg::kst_ctrl_type   ctrl,
   input  kst_pkg::kst_link_type   lower,
   input  kst_pkg::kst_link_type   upper,
   output kst_pkg::kst_link_type   link,
   output kst_pkg::kst_entry_type  entry_next,
   output logic                    valid_next,
   output logic                    held,
   output logic [7:0]              held_power
);
   import kst_pkg::*;

   kst_entry_type entry_ff;
   kst_entry_type entry_in;
   logic          valid_ff;
   logic          valid_in;
   logic          valid_eff;

   // A scan start empties the store before the current bin is considered.
   assign valid_eff = valid_ff && !ctrl.flush;

   // Flags seen by the neighbours: at or below the new power, and in the weakest run.
   assign link.valid = valid_eff;
   assign link.le    = valid_eff && (entry_ff.power <= ctrl.new_entry.power);
   assign link.mr    = valid_eff && (entry_ff.power == ctrl.min_power);
   assign link.entry = entry_ff;

   // Next content of this place of the ascending order.
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_eff;
      case (ctrl.op)
         OP_INSERT: begin
            // Entries above the insertion point move up by one place.
            valid_in = valid_eff || lower.valid;
            if (!link.le) begin
               if (lower.le) begin
                  entry_in = ctrl.new_entry;
               end else begin
                  entry_in = lower.entry;
               end
            end
         end
         OP_REPLACE: begin
            // The last entry of the weakest run leaves; entries up to the new one move down.
            if (!upper.mr && link.le) begin
               if (upper.le) begin
                  entry_in = upper.entry;
               end else begin
                  entry_in = ctrl.new_entry;
               end
            end
         end
         OP_REMOVE: begin
            // The last entry of the weakest run leaves and everything above moves down.
            if (!upper.mr) begin
               entry_in = upper.entry;
               valid_in = upper.valid;
            end
         end
         default: begin
            entry_in = entry_ff;
            valid_in = valid_eff;
         end
      endcase
   end

   assign entry_next = entry_in;
   assign valid_next = valid_in;
   assign held       = valid_ff;
   assign held_power = entry_ff.power;

   // The row end hands the contents to the drain and empties the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.clear ? 1'b0 : valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ----- hdl/kst_drain.sv -----
// Output drain: a shift line that takes a finished row and sends it one item per cycle
// while rsp_ready is high. Depends on kst_pkg for the entry and result types.
module kst_drain #(
   parameter int DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  kst_pkg::kst_entry_type  load_entry [DEPTH],
   input  logic [DEPTH-1:0]        load_valid,
   input  logic [8:0]              load_row,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output kst_pkg::kst_rsp_type    rsp_data
);
   import kst_pkg::*;

   kst_entry_type    entry_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [8:0]       row_ff;
   logic [DEPTH:0]   valid_ext;
   logic             pop;

   assign valid_ext = {1'b0, valid_ff};
   assign pop       = valid_ff[0] && rsp_ready;

   // Place 0 is the item on offer; the row is emitted weakest first.
   assign rsp_valid             = valid_ff[0];
   assign rsp_data.azimuth_row  = row_ff;
   assign rsp_data.bin_index    = entry_ff[0].index;
   assign rsp_data.bin_power    = entry_ff[0].power;
   assign rsp_data.last_target  = !valid_ext[1];

   // Valid bits of the shift line.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (load) begin
         valid_ff <= load_valid;
      end else if (pop) begin
         valid_ff <= valid_ext[DEPTH:1];
      end
   end

   // Payload of the shift line.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < DEPTH; i++) begin
            entry_ff[i] <= load_entry[i];
         end
         row_ff <= load_row;
      end else if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_ff[i] <= entry_ff[i + 1];
         end
      end
   end

endmodule

// ----- hdl/radar_k_strongest_filter.sv -----
// Top level of the k-strongest radar return filter: counters, control, cell row and drain.
// Depends on kst_pkg, kst_cell and kst_drain.
//
// Usage: range bins of one azimuth row enter on the req_ channel, one power byte per
// item, with last_bin on the final bin of the row and scan_start on the first bin of a
// scan. Bins before start_bin are ignored; the others compete for k_count places in a
// row of K_MAX cells kept in ascending power order, and one bin is taken every cycle
// unless held off. When the last bin of a row is accepted, the kept entries move into
// the drain and the store is empty for the next row at once. The drain offers
// the row's items on the rsp_ channel from the next cycle on, one per cycle while
// rsp_ready is high, weakest first, with last_target on the final one. A last_bin item
// is held off for the drain only while the drain still holds more than its final item, or
// that final item is not taken in the same cycle. If k_count is lowered in the middle
// of a row, the next considered bin waits while the weakest surplus entries are
// dropped one by one. The csr_ port writes k_count (index 0) and start_bin (index 1). A
// synchronous reset empties the store and the drain, zeroes the bin and row counters
// and restores k_count to 5 and start_bin to 50; no clearing pass follows.
module radar_k_strongest_filter #(
   parameter int K_MAX        = 16,
   parameter int BINS_MAX     = 4096,
   parameter int AZIMUTHS_MAX = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kst_pkg::kst_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kst_pkg::kst_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [11:0]          csr_wdata
);
   import kst_pkg::*;

   localparam int BW   = $clog2(BINS_MAX);
   localparam int RW   = (AZIMUTHS_MAX > 1) ? $clog2(AZIMUTHS_MAX) : 1;
   localparam int CNTW = $clog2(K_MAX + 1);
   localparam int KW   = (CNTW > 5) ? CNTW : 5;
   localparam int CW   = (BW > 12) ? BW : 12;

   logic [4:0]      k_count_ff;
   logic [11:0]     start_bin_ff;
   logic [BW-1:0]   bin_ff;
   logic [BW-1:0]   bin_eff;
   logic [RW-1:0]   row_ff;
   logic [RW-1:0]   row_eff;
   logic [CNTW-1:0] n_ff;
   logic [CNTW-1:0] n_eff;
   logic [KW-1:0]   k_eff;
   logic            scan;
   logic            considered;
   logic            trim;
   logic            drain_busy;
   logic            accept;
   kst_ctrl_type    ctrl;

   kst_link_type    links       [K_MAX];
   kst_link_type    lower_links [K_MAX];
   kst_link_type    upper_links [K_MAX];
   kst_entry_type   next_entry  [K_MAX];
   logic [7:0]      held_power  [K_MAX];
   logic [K_MAX-1:0] next_valid;
   logic [K_MAX-1:0] held_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff   <= K_COUNT_RESET;
         start_bin_ff <= START_BIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_K_COUNT:   k_count_ff   <= csr_wdata[4:0];
            CSR_START_BIN: start_bin_ff <= csr_wdata;
            default:       k_count_ff   <= k_count_ff;
         endcase
      end
   end

   // A scan start restarts the counters and drops a partial row before this bin.
   assign scan       = req_data.scan_start;
   assign bin_eff    = scan ? '0 : bin_ff;
   assign row_eff    = scan ? '0 : row_ff;
   assign n_eff      = scan ? '0 : n_ff;
   assign considered = CW'(bin_eff) >= CW'(start_bin_ff);
   assign k_eff      = (KW'(k_count_ff) > KW'(K_MAX)) ? KW'(K_MAX) : KW'(k_count_ff);

   // Surplus entries after k was lowered are dropped before the bin is considered.
   assign trim       = req_valid && !scan && considered && (KW'(n_ff) > k_eff);
   assign drain_busy = rsp_valid && (!rsp_data.last_target || !rsp_ready);
   assign req_ready  = !trim && !(req_data.last_bin && drain_busy);
   assign accept     = req_valid && req_ready;

   // Operation for the cell row in this cycle.
   always_comb begin
      ctrl.op              = OP_HOLD;
      ctrl.flush           = accept && scan;
      ctrl.clear           = accept && req_data.last_bin;
      ctrl.new_entry.power = req_data.power;
      ctrl.new_entry.index = 12'(bin_eff);
      ctrl.min_power       = held_power[0];
      if (trim) begin
         ctrl.op = OP_REMOVE;
      end else if (accept && considered && (k_eff != '0)) begin
         if (KW'(n_eff) < k_eff) begin
            ctrl.op = OP_INSERT;
         end else if (req_data.power > held_power[0]) begin
            ctrl.op = OP_REPLACE;
         end
      end
   end

   // Bin, row and fill counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff <= '0;
         row_ff <= '0;
         n_ff   <= '0;
      end else begin
         if (accept) begin
            if (req_data.last_bin) begin
               bin_ff <= '0;
               row_ff <= (row_eff == RW'(AZIMUTHS_MAX - 1)) ? '0 : row_eff + RW'(1);
            end else begin
               bin_ff <= (bin_eff < BW'(BINS_MAX - 1)) ? bin_eff + BW'(1) : bin_eff;
               row_ff <= row_eff;
            end
         end
         if (ctrl.clear) begin
            n_ff <= '0;
         end else if (ctrl.op == OP_REMOVE) begin
            n_ff <= n_ff - CNTW'(1);
         end else if (ctrl.op == OP_INSERT) begin
            n_ff <= n_eff + CNTW'(1);
         end else if (accept) begin
            n_ff <= n_eff;
         end
      end
   end

   // The row of cells, each linked to the places below and above it.
   for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lower_links[i] = '{valid: 1'b1, le: 1'b1, mr: 1'b0, entry: '0};
      end else begin : g_inner_lo
         assign lower_links[i] = links[i - 1];
      end
      if (i == K_MAX - 1) begin : g_last
         assign upper_links[i] = '0;
      end else begin : g_inner_hi
         assign upper_links[i] = links[i + 1];
      end
      kst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .lower      (lower_links[i]),
         .upper      (upper_links[i]),
         .link       (links[i]),
         .entry_next (next_entry[i]),
         .valid_next (next_valid[i]),
         .held       (held_valid[i]),
         .held_power (held_power[i])
      );
   end

   // The drain takes the row as it stands after its last bin.
   kst_drain #(
      .DEPTH (K_MAX)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (ctrl.clear),
      .load_entry (next_entry),
      .load_valid (next_valid),
      .load_row   (9'(row_eff)),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // The fill count always matches the occupied cells.
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(held_valid) == n_ff)
      else $error("fill count differs from occupied cells");

   // A row end leaves the store empty.
   a_row_end_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_bin) |=> (n_ff == '0))
      else $error("store not empty after row end");

   // Once the final item of a row is taken and no row is loaded, the drain is empty.
   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_target && !ctrl.clear) |=> !rsp_valid)
      else $error("drain still offers an item after the final one");

endmodule
